>>> design/scv_pkg.sv
package scv_pkg;

    // fixed field widths
    localparam int TAP_COUNT_W = 7;
    localparam int STRIDE_W    = 8;
    localparam int TAP_IDX_W   = 6;
    localparam int VALUE_W     = 16;
    localparam int ACC_W       = 40;
    localparam int OUT_IDX_W   = 16;
    localparam int TAPS_W      = 8;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;
    localparam int S_TDATA_W   = 24;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 56;

    // command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TAP_COUNT = 1'b0,
        CFG_STRIDE    = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        REQ_TAP    = 1'b0,
        REQ_SAMPLE = 1'b1
    } t_req;

    // one classified item for the back end
    typedef struct packed {
        logic                  is_tap;
        logic [TAP_IDX_W-1:0]  tap_index;
        logic [VALUE_W-1:0]    value;
        logic                  emit;
        logic [OUT_IDX_W-1:0]  out_index;
        logic [TAPS_W-1:0]     taps;
    } t_cmd;

endpackage

>>> design/scv_front.sv
module scv_front #(
    parameter int MAX_TAPS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [scv_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [scv_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [scv_pkg::S_TDATA_W-1:0]       i_tdata,
    input  logic [scv_pkg::S_TUSER_W-1:0]       i_tuser,
    output logic                                o_cmd_valid,
    output scv_pkg::t_cmd                       o_cmd,
    input  logic                                i_cmd_ready
);

    localparam int NW = $clog2(MAX_TAPS + 1);

    logic [scv_pkg::TAP_COUNT_W-1:0] r_tap_count;
    logic [scv_pkg::STRIDE_W-1:0]    r_stride;
    logic [NW-1:0]                   r_fill;
    logic [scv_pkg::STRIDE_W-1:0]    r_sdown;
    logic [scv_pkg::OUT_IDX_W-1:0]   r_ocnt;

    logic [NW-1:0]                   n_fill;
    logic [scv_pkg::STRIDE_W-1:0]    n_sdown;
    logic [scv_pkg::OUT_IDX_W-1:0]   n_ocnt;

    logic [NW-1:0]                   fc0;
    logic [scv_pkg::STRIDE_W-1:0]    sd0;
    logic [scv_pkg::OUT_IDX_W-1:0]   oc0;
    logic [scv_pkg::TAPS_W-1:0]      tc_ext;
    logic [scv_pkg::TAPS_W-1:0]      taps8;
    logic [NW-1:0]                   n_taps;
    logic                            is_sample;
    logic                            frame_start;
    logic                            emit;
    logic                            accept;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = i_cmd_ready;
    assign o_cmd_valid = i_valid;
    assign accept      = i_valid & i_cmd_ready;

    assign is_sample   = (scv_pkg::t_req'(i_tuser[0]) == scv_pkg::REQ_SAMPLE);
    assign frame_start = i_tuser[1];

    // effective tap count: zero acts as one, clipped to the store depth
    assign tc_ext = scv_pkg::TAPS_W'(r_tap_count);
    always_comb begin
        if (tc_ext == '0) begin
            taps8 = scv_pkg::TAPS_W'(1);
        end else if (tc_ext > scv_pkg::TAPS_W'(MAX_TAPS)) begin
            taps8 = scv_pkg::TAPS_W'(MAX_TAPS);
        end else begin
            taps8 = tc_ext;
        end
    end
    assign n_taps = NW'(taps8);

    always_comb begin
        fc0     = frame_start ? '0 : r_fill;
        sd0     = frame_start ? '0 : r_sdown;
        oc0     = frame_start ? '0 : r_ocnt;
        emit    = 1'b0;
        n_fill  = fc0;
        n_sdown = sd0;
        if (fc0 < n_taps) begin
            n_fill = fc0 + NW'(1);
            if (n_fill == n_taps) begin
                emit    = 1'b1;
                n_sdown = r_stride;
            end
        end else begin
            n_sdown = sd0 - scv_pkg::STRIDE_W'(1);
            if (n_sdown == '0) begin
                emit    = 1'b1;
                n_sdown = r_stride;
            end
        end
        n_ocnt = emit ? oc0 + scv_pkg::OUT_IDX_W'(1) : oc0;
    end

    always_comb begin
        o_cmd.is_tap    = ~is_sample;
        o_cmd.tap_index = i_tdata[scv_pkg::TAP_IDX_W-1:0];
        o_cmd.value     = i_tdata[scv_pkg::TAP_IDX_W +: scv_pkg::VALUE_W];
        o_cmd.emit      = is_sample & emit;
        o_cmd.out_index = oc0;
        o_cmd.taps      = taps8;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= scv_pkg::TAP_COUNT_W'(1);
            r_stride    <= scv_pkg::STRIDE_W'(1);
        end else if (i_cfg_valid) begin
            unique case (scv_pkg::t_cfg_idx'(i_cfg_index))
                scv_pkg::CFG_TAP_COUNT: r_tap_count <= i_cfg_data[scv_pkg::TAP_COUNT_W-1:0];
                scv_pkg::CFG_STRIDE:    r_stride    <= i_cfg_data[scv_pkg::STRIDE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_sdown <= '0;
            r_ocnt  <= '0;
        end else if (accept && is_sample) begin
            r_fill  <= n_fill;
            r_sdown <= n_sdown;
            r_ocnt  <= n_ocnt;
        end
    end

endmodule

>>> design/scv_queue.sv
module scv_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  scv_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output scv_pkg::t_cmd o_cmd
);

    localparam int CW = scv_pkg::Q_AW + 1;

    scv_pkg::t_cmd             r_mem [scv_pkg::Q_DEPTH];
    logic [scv_pkg::Q_AW-1:0]  r_wr;
    logic [scv_pkg::Q_AW-1:0]  r_rd;
    logic [CW-1:0]             r_cnt;
    logic                      do_push;
    logic                      do_pop;

    assign o_full  = (r_cnt == CW'(scv_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + scv_pkg::Q_AW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + scv_pkg::Q_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

>>> design/scv_back.sv
module scv_back #(
    parameter int MAX_TAPS    = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cmd_valid,
    input  scv_pkg::t_cmd                      i_cmd,
    output logic                               o_cmd_take,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [scv_pkg::ACC_W-1:0]          o_value,
    output logic [scv_pkg::OUT_IDX_W-1:0]      o_index
);

    localparam int AW = $clog2(MAX_TAPS);
    localparam int PW = 2 * SAMPLE_BITS;
    localparam int EW = (PW > scv_pkg::ACC_W) ? PW : scv_pkg::ACC_W;
    localparam int SW = scv_pkg::TAPS_W + 1;

    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_MAC  = 2'b10
    } t_bstate;

    logic [SAMPLE_BITS-1:0] tap_mem [MAX_TAPS];
    logic [SAMPLE_BITS-1:0] win_mem [MAX_TAPS];

    t_bstate                        r_state;
    logic [AW-1:0]                  r_wp;
    logic [scv_pkg::TAPS_W-1:0]     r_k;
    logic [scv_pkg::TAPS_W-1:0]     r_taps;
    logic [AW-1:0]                  r_waddr;
    logic                           r_rd_v;
    logic                           r_rd_last;
    logic                           r_pv;
    logic                           r_plast;
    logic signed [SAMPLE_BITS-1:0]  r_tap_q;
    logic signed [SAMPLE_BITS-1:0]  r_win_q;
    logic signed [PW-1:0]           r_prod;
    logic [scv_pkg::ACC_W-1:0]      r_acc;
    logic [scv_pkg::OUT_IDX_W-1:0]  r_idx;
    logic                           r_out_valid;
    logic [scv_pkg::ACC_W-1:0]      r_out_value;
    logic [scv_pkg::OUT_IDX_W-1:0]  r_out_index;

    logic                           out_free;
    logic                           take;
    logic                           issue;
    logic                           issue_last;
    logic signed [31:0]             val32;
    logic [SAMPLE_BITS-1:0]         val_s;
    logic [AW-1:0]                  n_wp;
    logic [SW-1:0]                  wp_ext;
    logic [SW-1:0]                  tm1;
    logic [SW-1:0]                  base;
    logic [AW-1:0]                  n_start;
    logic [AW-1:0]                  n_waddr;
    logic signed [EW-1:0]           prod_ext;
    logic [scv_pkg::ACC_W-1:0]      acc_sum;
    logic                           fin;

    assign out_free   = ~r_out_valid | i_ready;
    assign take       = i_cmd_valid && (r_state == B_IDLE) && (!i_cmd.emit || out_free);
    assign o_cmd_take = take;

    assign val32 = 32'(signed'(i_cmd.value));
    assign val_s = val32[SAMPLE_BITS-1:0];

    // circular window: newest sample at r_wp
    assign n_wp   = (r_wp == AW'(MAX_TAPS - 1)) ? '0 : r_wp + AW'(1);
    assign wp_ext = SW'(n_wp);
    assign tm1    = SW'(i_cmd.taps) - SW'(1);
    assign base   = (wp_ext >= tm1) ? wp_ext : wp_ext + SW'(MAX_TAPS);
    assign n_start = AW'(base - tm1);
    assign n_waddr = (r_waddr == AW'(MAX_TAPS - 1)) ? '0 : r_waddr + AW'(1);

    assign issue      = (r_state == B_MAC) && (r_k < r_taps);
    assign issue_last = issue && (r_k == r_taps - scv_pkg::TAPS_W'(1));

    assign prod_ext = EW'(r_prod);
    assign acc_sum  = r_acc + prod_ext[scv_pkg::ACC_W-1:0];
    assign fin      = r_pv & r_plast;

    // store writes
    always_ff @(posedge i_clk) begin
        if (take && i_cmd.is_tap && (32'(i_cmd.tap_index) < MAX_TAPS)) begin
            tap_mem[AW'(i_cmd.tap_index)] <= val_s;
        end
        if (take && !i_cmd.is_tap) begin
            win_mem[n_wp] <= val_s;
        end
    end

    // registered reads
    always_ff @(posedge i_clk) begin
        r_tap_q <= tap_mem[r_k[AW-1:0]];
        r_win_q <= win_mem[r_waddr];
    end

    // multiply and accumulate stages
    always_ff @(posedge i_clk) begin
        r_prod <= r_tap_q * r_win_q;
        if (take && i_cmd.emit) begin
            r_acc <= '0;
        end else if (r_pv) begin
            r_acc <= acc_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && !i_cmd.is_tap && i_cmd.emit) begin
            r_taps <= i_cmd.taps;
            r_idx  <= i_cmd.out_index;
        end
        if (fin) begin
            r_out_value <= acc_sum;
            r_out_index <= r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_wp        <= '0;
            r_k         <= '0;
            r_waddr     <= '0;
            r_rd_v      <= 1'b0;
            r_rd_last   <= 1'b0;
            r_pv        <= 1'b0;
            r_plast     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_v    <= issue;
            r_rd_last <= issue_last;
            r_pv      <= r_rd_v;
            r_plast   <= r_rd_last;
            unique case (r_state)
                B_IDLE: begin
                    if (take && !i_cmd.is_tap) begin
                        r_wp <= n_wp;
                        if (i_cmd.emit) begin
                            r_state <= B_MAC;
                            r_k     <= '0;
                            r_waddr <= n_start;
                        end
                    end
                end
                B_MAC: begin
                    if (issue) begin
                        r_k     <= r_k + scv_pkg::TAPS_W'(1);
                        r_waddr <= n_waddr;
                    end
                    if (fin) begin
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
            if (fin) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_value = r_out_value;
    assign o_index = r_out_index;

endmodule

>>> design/strided_conv1d_engine.sv
// strided 1d correlation, valid mode, with a configurable stride
// input stream: each transaction is either a tap write (tuser[0] = 0) that
//   stores one q1.15 coefficient, or a sample push (tuser[0] = 1); tuser[1]
//   on a sample starts a new frame and clears the fill, stride and index state
// output stream: one transaction per finished window, carrying the 40-bit
//   dot product (q10.30) and its index within the frame
// config channel: index 0 sets tap_count, index 1 sets stride; always ready,
//   and only to be written while the engine is idle
// timing: the shared multiply-accumulate reads one tap from each store per cycle,
//   and the back end takes no new command until the current window's result
//   is in the output register; all other transactions are taken while it is idle,
//   and a two-entry command queue lets the input side run ahead of the accumulator
// reset: tap_count and stride return to 1, frame counters clear; the tap and
//   window stores keep whatever they held
// stall: the result sits in an output register; while it waits, tap writes
//   and non-emitting samples still drain, and the next emitting sample waits
module strided_conv1d_engine #(
    parameter int MAX_TAPS    = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [scv_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [scv_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input stream
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [5:0] tap_index, [21:6] value, [23:22] zero
    input  logic [scv_pkg::S_TDATA_W-1:0]      i_s_axis_tdata,
    // [0] req_type, [1] frame_start
    input  logic [scv_pkg::S_TUSER_W-1:0]      i_s_axis_tuser,
    // output stream
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [39:0] out_value, [55:40] out_index
    output logic [scv_pkg::M_TDATA_W-1:0]      o_m_axis_tdata
);

    scv_pkg::t_cmd                  front_cmd;
    scv_pkg::t_cmd                  q_cmd;
    logic                           front_valid;
    logic                           q_full;
    logic                           q_valid;
    logic                           q_pop;
    logic [scv_pkg::ACC_W-1:0]      out_value;
    logic [scv_pkg::OUT_IDX_W-1:0]  out_index;

    // front end: register file, frame counters, emit decision
    scv_front #(
        .MAX_TAPS (MAX_TAPS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_tdata     (i_s_axis_tdata),
        .i_tuser     (i_s_axis_tuser),
        .o_cmd_valid (front_valid),
        .o_cmd       (front_cmd),
        .i_cmd_ready (~q_full)
    );

    // decoupling queue
    scv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // back end: tap and window stores, shared multiply-accumulate
    scv_back #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_take  (q_pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_value     (out_value),
        .o_index     (out_index)
    );

    assign o_m_axis_tdata = {out_index, out_value};

endmodule
